@@ design/swm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

   localparam int DATA_W = 32;
   localparam int CSR_W  = 5;
   localparam logic [CSR_W-1:0] WINDOW_SIZE_RESET = 5'd3;

   // Running count of cells marked for removal, passed down the cell chain.
   typedef enum logic [1:0] {
      DEL_NONE = 2'd0,
      DEL_ONE  = 2'd1,
      DEL_MANY = 2'd2
   } del_count_type;

   typedef struct packed {
      logic le;     // occupied and value <= incoming sample
      logic mark;   // occupied and aged out of the window
   } cell_flag_type;

   typedef struct packed {
      logic step;     // a sample transfer updates the chain
      logic purge;    // remove the first marked cell, no insertion
      logic restart;  // window is emptied before this sample
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ design/swm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface swm_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [swm_pkg::DATA_W-1:0] sample;
   logic                              restart;

   modport source (output valid, output sample, output restart, input ready);
   modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [swm_pkg::DATA_W-1:0] median;

   modport source (output valid, output median, input ready);
   modport sink   (input valid, input median, output ready);
endinterface

`default_nettype wire

@@ design/swm_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swm_cell #(
   parameter int WINDOW_MAX = 16,
   parameter int INDEX      = 0,
   parameter int KW         = $clog2(WINDOW_MAX + 1),
   parameter int AW         = $clog2(WINDOW_MAX)
) (
   input  logic                              clock,
   input  swm_pkg::cell_ctl_type             ctl,
   input  logic signed [swm_pkg::DATA_W-1:0] sample,
   input  logic [KW-1:0]                     k,
   input  logic [KW-1:0]                     fill,
   input  logic signed [swm_pkg::DATA_W-1:0] left_value,
   input  logic [AW-1:0]                     left_age,
   input  swm_pkg::cell_flag_type            left_flag,
   input  logic signed [swm_pkg::DATA_W-1:0] right_value,
   input  logic [AW-1:0]                     right_age,
   input  swm_pkg::cell_flag_type            right_flag,
   input  swm_pkg::del_count_type            del_in,
   output logic signed [swm_pkg::DATA_W-1:0] value,
   output logic [AW-1:0]                     age,
   output swm_pkg::cell_flag_type            flag,
   output swm_pkg::del_count_type            del_out,
   output logic signed [swm_pkg::DATA_W-1:0] next_value
);
   import swm_pkg::*;

   localparam logic [KW-1:0] INDEX_K = KW'(INDEX);
   localparam bit            FIRST   = (INDEX == 0);

   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [AW-1:0]            age_ff, age_in;

   logic                     occupied;
   logic [KW-1:0]            age_plus;
   logic                     before_prev, before_cur;
   logic signed [DATA_W-1:0] cur_value, prev_value;
   logic [AW-1:0]            cur_age, prev_age;
   logic                     cur_le, prev_le, insert_here;
   logic signed [DATA_W-1:0] step_value;
   logic [AW-1:0]            step_age;

   always_comb begin
      occupied  = INDEX_K < fill;
      age_plus  = KW'(age_ff) + 1'b1;
      flag.le   = occupied && (value_ff <= sample);
      flag.mark = occupied && (age_plus >= k);

      // The first marked cell is the one that leaves; cells past it close the gap.
      before_prev = (del_in == DEL_NONE);
      before_cur  = before_prev && !flag.mark;

      cur_value  = before_cur ? value_ff : right_value;
      cur_age    = before_cur ? age_ff : right_age;
      cur_le     = (before_cur ? flag.le : right_flag.le) && !ctl.restart;
      prev_value = before_prev ? left_value : value_ff;
      prev_age   = before_prev ? left_age : age_ff;
      prev_le    = (before_prev ? left_flag.le : flag.le) && !ctl.restart;
      insert_here = FIRST || prev_le;

      if (cur_le) begin
         step_value = cur_value;
         step_age   = cur_age + 1'b1;
      end else if (insert_here) begin
         step_value = sample;
         step_age   = '0;
      end else begin
         step_value = prev_value;
         step_age   = prev_age + 1'b1;
      end

      value_in = value_ff;
      age_in   = age_ff;
      if (ctl.step) begin
         value_in = step_value;
         age_in   = step_age;
      end else if (ctl.purge) begin
         value_in = cur_value;
         age_in   = cur_age;
      end

      unique case (del_in)
         DEL_NONE: del_out = flag.mark ? DEL_ONE : DEL_NONE;
         DEL_ONE:  del_out = flag.mark ? DEL_MANY : DEL_ONE;
         default:  del_out = DEL_MANY;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      age_ff   <= age_in;
   end

   assign value      = value_ff;
   assign age        = age_ff;
   assign next_value = step_value;

endmodule

`default_nettype wire

@@ design/swm_rsp_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swm_rsp_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic signed [swm_pkg::DATA_W-1:0] push_median,
   output logic                              ready,
   swm_rsp_if.source                         rsp_if
);
   import swm_pkg::*;

   logic                     out_valid_ff, out_valid_in;
   logic signed [DATA_W-1:0] out_data_ff, out_data_in;
   logic                     skid_valid_ff, skid_valid_in;
   logic signed [DATA_W-1:0] skid_data_ff, skid_data_in;
   logic                     pop;

   always_comb begin
      pop           = out_valid_ff && rsp_if.ready;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // no push can arrive while the skid entry is full
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_in = push;
         out_data_in  = push_median;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_median;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign ready         = !skid_valid_ff;
   assign rsp_if.valid  = out_valid_ff;
   assign rsp_if.median = out_data_ff;

endmodule

`default_nettype wire

@@ design/sliding_window_median_core.sv @@
// A result is registered in the result queue on the sample transfer that completes it.
// Throughput: one sample per cycle unless a purge or a full result queue holds req_if;
//   the sorted chain inserts the new sample and drops the oldest in the same cycle.
// After the window is shrunk, each sample beyond the new size is removed by a purge
//   before the next sample is taken; the result queue holds two entries.
// Reset: window size 3, window empty, result queue empty; cell contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median_core #(
   parameter int WINDOW_MAX = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [swm_pkg::CSR_W-1:0]  csr_write_data,
   swm_req_if.sink                    req_if,
   swm_rsp_if.source                  rsp_if
);
   import swm_pkg::*;

   localparam int KW = $clog2(WINDOW_MAX + 1);
   localparam int AW = $clog2(WINDOW_MAX);
   localparam int CW = (KW > CSR_W) ? KW : CSR_W;

   logic [CSR_W-1:0] window_size_ff, window_size_in;
   logic [KW-1:0]    fill_count_ff, fill_count_in;

   logic [CW-1:0]    size_ext, size_sat;
   logic [KW-1:0]    k_eff;
   logic [KW-1:0]    k_less;
   logic [AW-1:0]    median_idx;
   logic [KW-1:0]    fill_next;
   logic             removal, multi, purge, fifo_ready, step, push;
   cell_ctl_type     ctl;

   // Neighbor views, offset by one so both chain ends tie off.
   logic signed [DATA_W-1:0] view_value [WINDOW_MAX+2];
   logic [AW-1:0]            view_age   [WINDOW_MAX+2];
   cell_flag_type            view_flag  [WINDOW_MAX+2];
   del_count_type            del_chain  [WINDOW_MAX+1];
   logic signed [DATA_W-1:0] cell_next  [WINDOW_MAX];

   assign view_value[0]            = '0;
   assign view_age[0]              = '0;
   assign view_flag[0]             = '0;
   assign view_value[WINDOW_MAX+1] = '0;
   assign view_age[WINDOW_MAX+1]   = '0;
   assign view_flag[WINDOW_MAX+1]  = '0;
   assign del_chain[0]             = DEL_NONE;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swm_cell #(
         .WINDOW_MAX (WINDOW_MAX),
         .INDEX      (i),
         .KW         (KW),
         .AW         (AW)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .sample      (req_if.sample),
         .k           (k_eff),
         .fill        (fill_count_ff),
         .left_value  (view_value[i]),
         .left_age    (view_age[i]),
         .left_flag   (view_flag[i]),
         .right_value (view_value[i+2]),
         .right_age   (view_age[i+2]),
         .right_flag  (view_flag[i+2]),
         .del_in      (del_chain[i]),
         .value       (view_value[i+1]),
         .age         (view_age[i+1]),
         .flag        (view_flag[i+1]),
         .del_out     (del_chain[i+1]),
         .next_value  (cell_next[i])
      );
   end

   always_comb begin
      size_ext = CW'(window_size_ff);
      if (size_ext == '0) begin
         size_sat = CW'(1);
      end else if (size_ext > CW'(WINDOW_MAX)) begin
         size_sat = CW'(WINDOW_MAX);
      end else begin
         size_sat = size_ext;
      end
      k_eff      = size_sat[KW-1:0];
      k_less     = k_eff - 1'b1;
      median_idx = AW'(k_less >> 1);

      removal = (del_chain[WINDOW_MAX] != DEL_NONE);
      multi   = (del_chain[WINDOW_MAX] == DEL_MANY);
      // aged-out samples leave only once the next sample is offered
      purge   = multi && req_if.valid;

      req_if.ready = !multi && fifo_ready;
      step         = req_if.valid && req_if.ready;

      ctl.step    = step;
      ctl.purge   = purge;
      ctl.restart = req_if.restart;

      if (req_if.restart) begin
         fill_next = KW'(1);
      end else if (removal) begin
         fill_next = fill_count_ff;
      end else begin
         fill_next = fill_count_ff + 1'b1;
      end

      fill_count_in = fill_count_ff;
      if (step) begin
         fill_count_in = fill_next;
      end else if (purge) begin
         fill_count_in = fill_count_ff - 1'b1;
      end

      push = step && (fill_next == k_eff);

      window_size_in = csr_write_enable ? csr_write_data : window_size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
         fill_count_ff  <= '0;
      end else begin
         window_size_ff <= window_size_in;
         fill_count_ff  <= fill_count_in;
      end
   end

   swm_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_median (cell_next[median_idx]),
      .ready       (fifo_ready),
      .rsp_if      (rsp_if)
   );

   a_restart_fill: assert property (@(posedge clock) disable iff (reset)
      step && req_if.restart |=> fill_count_ff == KW'(1))
      else $error("restart transfer did not leave one sample in the window");

   a_purge_shrinks: assert property (@(posedge clock) disable iff (reset)
      purge |=> (fill_count_ff + 1'b1) == $past(fill_count_ff))
      else $error("purge cycle did not drop exactly one sample");

   a_grow_fill: assert property (@(posedge clock) disable iff (reset)
      step && !req_if.restart && !removal |=> fill_count_ff == $past(fill_count_ff) + 1'b1)
      else $error("window did not grow by one sample");

endmodule

`default_nettype wire

@@ tb/tb_sliding_window_median_core.sv @@
`timescale 1ns / 1ps

module tb_sliding_window_median_core;
   import swm_pkg::*;

   localparam int WIN_DEPTH   = 16;
   localparam int RAND_ITEMS  = 2000;
   localparam int PHASE_ITEMS = 120;

   typedef enum logic [1:0] {
      ROW_CFG   = 2'd0,  // write window size
      ROW_PRED  = 2'd1,  // median from the predictor
      ROW_NONE  = 2'd2,  // typed: no median
      ROW_VALUE = 2'd3   // typed: median given in the row
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic         restart;
      logic [31:0]  sample;
      logic [31:0]  median;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_W-1:0] csr_write_data;

   swm_req_if req_bus ();
   swm_rsp_if rsp_bus ();

   sliding_window_median_core #(.WINDOW_MAX(WIN_DEPTH)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus)
   );

   // predictor state
   logic [CSR_W-1:0]          window_reg;
   logic signed [DATA_W-1:0]  win_value [WIN_DEPTH];
   int                        win_age [WIN_DEPTH];
   int                        win_fill;

   logic signed [DATA_W-1:0]  pending_medians [$];

   int err_count;
   int items_sent;
   int restarts_sent;
   int medians_checked;
   int cfg_writes;
   int stall_left;
   bit no_gaps;

   stim_row_type dir_rows [26] = '{
      '{ROW_NONE,  1'b1, 32'h8000_0000, 32'h0},
      '{ROW_NONE,  1'b0, 32'h7FFF_FFFF, 32'h0},
      '{ROW_VALUE, 1'b0, 32'h0000_0000, 32'h0000_0000},
      '{ROW_VALUE, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000},
      '{ROW_VALUE, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{ROW_NONE,  1'b1, 32'd5,         32'h0},
      '{ROW_CFG,   1'b0, 32'd1,         32'h0},
      '{ROW_VALUE, 1'b0, 32'h8000_0000, 32'h8000_0000},
      '{ROW_VALUE, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      '{ROW_CFG,   1'b0, 32'd0,         32'h0},
      '{ROW_VALUE, 1'b1, 32'd12345,     32'd12345},
      '{ROW_CFG,   1'b0, 32'd2,         32'h0},
      '{ROW_VALUE, 1'b0, 32'd7,         32'd7},
      '{ROW_VALUE, 1'b0, 32'd3,         32'd3},
      '{ROW_CFG,   1'b0, 32'd4,         32'h0},   // grow while filled
      '{ROW_NONE,  1'b0, 32'd1,         32'h0},
      '{ROW_PRED,  1'b0, 32'd9,         32'h0},
      '{ROW_CFG,   1'b0, 32'd2,         32'h0},   // shrink while filled
      '{ROW_PRED,  1'b0, 32'd100,       32'h0},
      '{ROW_PRED,  1'b0, 32'd9,         32'h0},
      '{ROW_PRED,  1'b1, 32'd42,        32'h0},
      '{ROW_PRED,  1'b0, 32'd42,        32'h0},   // equal samples
      '{ROW_CFG,   1'b0, 32'd31,        32'h0},   // saturates to full depth
      '{ROW_PRED,  1'b1, 32'h8000_0000, 32'h0},
      '{ROW_PRED,  1'b0, 32'h7FFF_FFFF, 32'h0},
      '{ROW_PRED,  1'b0, 32'h0000_0000, 32'h0}
   };

   int window_plan [12] = '{31, 16, 0, 1, 2, 15, 17, 4, 3, 16, 5, 8};

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(10_000_000);
      $display("status: fail");
      $finish;
   end

   // Ages every stored sample, drops the ones that left the window, adds the new one, gives the median once full.
   function automatic bit median_step(input logic signed [DATA_W-1:0] smp, input bit rst,
                                      output logic signed [DATA_W-1:0] med);
      int k;
      int kept;
      int j;
      logic signed [DATA_W-1:0] srt [WIN_DEPTH];
      logic signed [DATA_W-1:0] v;
      if (window_reg == 0) k = 1;
      else if (window_reg > WIN_DEPTH) k = WIN_DEPTH;
      else k = window_reg;
      if (rst) win_fill = 0;
      kept = 0;
      med = '0;
      for (int i = 0; i < win_fill; i++) begin
         if (win_age[i] + 1 < k) begin
            win_value[kept] = win_value[i];
            win_age[kept]   = win_age[i] + 1;
            kept++;
         end
      end
      win_value[kept] = smp;
      win_age[kept]   = 0;
      win_fill        = kept + 1;
      if (win_fill != k) return 1'b0;
      for (int i = 0; i < win_fill; i++) begin
         v = win_value[i];
         j = i;
         while (j > 0 && srt[j-1] > v) begin
            srt[j] = srt[j-1];
            j--;
         end
         srt[j] = v;
      end
      med = srt[(k + 1) / 2 - 1];
      return 1'b1;
   endfunction

   function automatic logic [31:0] draw_sample();
      logic [31:0] s;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: s = 32'h8000_0000;
               1: s = 32'h7FFF_FFFF;
               2: s = 32'h0000_0000;
               default: s = 32'hFFFF_FFFF;
            endcase
         end
         1, 2, 3: s = $urandom_range(0, 8) - 4;  // narrow range, lots of duplicates
         default: s = $urandom;
      endcase
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic signed [DATA_W-1:0] want,
                                  input logic signed [DATA_W-1:0] got);
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
      err_count++;
   endtask

   task automatic send_sample(input bit rst, input logic [31:0] smp, input bit typed,
                              input bit typed_has, input logic [31:0] typed_med);
      int gap;
      bit has;
      logic signed [DATA_W-1:0] med;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.sample  <= smp;
      req_bus.restart <= rst;
      do @(posedge clock); while (!req_bus.ready);
      has = median_step(smp, rst, med);
      if (typed) begin
         if (typed_has) pending_medians.insert(pending_medians.size(), typed_med);
      end else if (has) begin
         pending_medians.insert(pending_medians.size(), med);
      end
      items_sent++;
      if (rst) restarts_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_medians.size() != 0) @(posedge clock);
   endtask

   task automatic write_window(input logic [31:0] value);
      wait_drained();
      // purge cycles of a shrink only start with the next sample
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value[CSR_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      window_reg = value[CSR_W-1:0];
      cfg_writes++;
   endtask

   // result side: check each transfer, then draw the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_medians.size() == 0) begin
               report_mismatch("median with none pending", 'x, rsp_bus.median);
            end else begin
               if (rsp_bus.median !== pending_medians[0])
                  report_mismatch("median", pending_medians[0], rsp_bus.median);
               void'(pending_medians.pop_front());
            end
            medians_checked++;
            stall_left = no_gaps ? 0 : $urandom_range(0, 8);
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int rand_items;
      int phase;
      int win_setting;
      bit rst;
      err_count        = 0;
      items_sent       = 0;
      restarts_sent    = 0;
      medians_checked  = 0;
      cfg_writes       = 0;
      no_gaps          = 1'b0;
      window_reg       = WINDOW_SIZE_RESET;
      win_fill         = 0;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.sample   <= '0;
      req_bus.restart  <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         case (dir_rows[i].kind)
            ROW_CFG:   write_window(dir_rows[i].sample);
            ROW_PRED:  send_sample(dir_rows[i].restart, dir_rows[i].sample, 1'b0, 1'b0, '0);
            ROW_NONE:  send_sample(dir_rows[i].restart, dir_rows[i].sample, 1'b1, 1'b0, '0);
            default:   send_sample(dir_rows[i].restart, dir_rows[i].sample, 1'b1, 1'b1,
                                   dir_rows[i].median);
         endcase
      end

      rand_items = 0;
      phase = 0;
      while (rand_items < RAND_ITEMS) begin
         win_setting = (phase < 12) ? window_plan[phase] : $urandom_range(0, 31);
         write_window(win_setting);
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            rst = ($urandom_range(0, 39) == 0) || (n == 0 && $urandom_range(0, 1) == 1);
            send_sample(rst, draw_sample(), 1'b0, 1'b0, '0);
            if (n == PHASE_ITEMS / 2 && $urandom_range(0, 2) == 0) wait_drained();
         end
         rand_items += PHASE_ITEMS;
         phase++;
      end

      wait_drained();
      repeat (20) @(posedge clock);

      $display("covered %0d samples (%0d with restart), %0d medians checked",
               items_sent, restarts_sent, medians_checked);
      $display("window size written %0d times, including 0, 1, 16 and above 16", cfg_writes);
      if (err_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ sliding_window_median_core.f @@
design/swm_pkg.sv
design/swm_if.sv
design/swm_cell.sv
design/swm_rsp_fifo.sv
design/sliding_window_median_core.sv
tb/tb_sliding_window_median_core.sv
